>>> rtl/core/fcgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcgb_pkg
// Shared constants for the flag count (Gaussian binomial) unit.
// ----------------------------------------------------------------------------
package fcgb_pkg;
  localparam int unsigned MaxReducedK = 32;
  localparam int unsigned MaxReducedN = 64;
  localparam int unsigned WordW       = 64;
  localparam int unsigned OutDataW    = 72;  // count + status, byte padded
  localparam int unsigned CfgIdxW     = 2;

  localparam logic [CfgIdxW-1:0] RegFieldSize = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSpaceDim  = 2'd1;

  localparam logic [WordW-1:0] FieldSizeReset = 64'd2;

  typedef struct packed {
    logic            start;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
  } mac_req_t;

  typedef struct packed {
    logic            done;
    logic            ovf;
    logic [WordW-1:0] res;
  } mac_rsp_t;
endpackage

>>> rtl/core/fcgb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcgb_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module fcgb_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr_a,
  input  logic [$clog2(Depth)-1:0] raddr_b,
  output logic [Width-1:0]         rdata_a,
  output logic [Width-1:0]         rdata_b
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

>>> rtl/core/fcgb_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcgb_mac
// Multi-cycle 64x64 multiply-add with 64-bit overflow detect.
// Four 32x32 partial products, one per cycle; done is raised with the registered result.
// ----------------------------------------------------------------------------
module fcgb_mac (
  input  logic                      clk,
  input  logic                      rst,
  input  fcgb_pkg::mac_req_t        req,
  output fcgb_pkg::mac_rsp_t        rsp
);
  import fcgb_pkg::*;

  logic [WordW-1:0]   a, b, c;
  logic [2:0]         step;
  logic               busy;
  logic [63:0]        pp;
  logic [127:0]       acc;
  logic [31:0]        ah, bh;
  logic [1:0]         pidx;
  logic [127:0]       addend;
  logic [64:0]        fsum;
  logic               done_q, ovf_q;
  logic [WordW-1:0]   res_q;

  assign pidx = step[1:0];
  assign ah   = pidx[0] ? a[63:32] : a[31:0];
  assign bh   = pidx[1] ? b[63:32] : b[31:0];

  assign rsp = {done_q, ovf_q, res_q};

  // weight of the product formed in the previous step
  always_comb begin
    unique case (step[1:0] - 2'd1)
      2'd0:    addend = {64'd0, pp};
      2'd1:    addend = {32'd0, pp, 32'd0};
      2'd2:    addend = {32'd0, pp, 32'd0};
      default: addend = {pp, 64'd0};
    endcase
  end

  assign fsum = {1'b0, acc[63:0]} + {1'b0, c};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      step   <= 3'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 3'd0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == 3'd5) begin
          busy   <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a   <= req.a;
      b   <= req.b;
      c   <= req.c;
      acc <= '0;
    end else if (busy) begin
      if (step < 3'd4) begin
        pp <= ah * bh;
      end
      if (step >= 3'd1 && step <= 3'd4) begin
        acc <= acc + addend;
      end
      if (step == 3'd5) begin
        res_q <= fsum[63:0];
        ovf_q <= (|acc[127:64]) | fsum[64];
      end
    end
  end
endmodule

>>> rtl/core/flag_count_gaussian_binomial_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flag_count_gaussian_binomial_unit
// Counts flags over GF(q): product of Gaussian binomials, one per dimension.
// ----------------------------------------------------------------------------
//  channel   dir  fields (low bit up)          handshake
//  s_axis    in   tdata: dim[63:0]; tlast      tvalid/tready
//  m_axis    out  tdata: count, status, pad    tvalid/tready
//  cfg       in   0 field_size, 1 space_dim    cfg_we
//
// One word at a time. A word with reduced k = 0 goes through prep and a single
// multiply into the product; a skipped word goes straight to finish. Reduced
// k >= 1 adds table setup (one multiply per power of q), a final table read and
// one multiply-add per recurrence cell (sum of min(i,k) over n rows, at most
// 1552 for n = 64, k = 32), all on the one shared multiply-add unit and the
// row and power tables. Reset is synchronous; tables need no clearing.
// A finished count waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module flag_count_gaussian_binomial_unit #(
  parameter int unsigned MAX_REDUCED_K = fcgb_pkg::MaxReducedK,
  parameter int unsigned MAX_REDUCED_N = fcgb_pkg::MaxReducedN
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [fcgb_pkg::WordW-1:0]     s_axis_tdata,   // dim[63:0]
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [fcgb_pkg::OutDataW-1:0]  m_axis_tdata,   // count[63:0], status[64], 0
  input  logic                           cfg_we,
  input  logic [fcgb_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [fcgb_pkg::WordW-1:0]     cfg_data
);
  import fcgb_pkg::*;

  localparam int unsigned Depth = MAX_REDUCED_K + 1;
  localparam int unsigned IW    = $clog2(Depth);
  localparam int unsigned NW    = $clog2(MAX_REDUCED_N + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PREP   = 4'd1;
  localparam logic [3:0] S_PREP2  = 4'd2;
  localparam logic [3:0] S_ISTART = 4'd3;
  localparam logic [3:0] S_IWAIT  = 4'd4;
  localparam logic [3:0] S_RRD    = 4'd5;
  localparam logic [3:0] S_RDAT   = 4'd6;
  localparam logic [3:0] S_RWAIT  = 4'd7;
  localparam logic [3:0] S_FRD    = 4'd8;
  localparam logic [3:0] S_FDAT   = 4'd9;
  localparam logic [3:0] S_PWAIT  = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  logic [3:0]       state;
  logic [WordW-1:0] field_size, space_dim;
  logic [WordW-1:0] prod, prev, d;
  logic             last, started, inv_seen, ovf_seen, one_fac;
  logic [WordW-1:0] nn64, kk64, k64, pw;
  logic [NW-1:0]    nn, i;
  logic [IW-1:0]    k, j;
  logic [NW:0]      inext;
  logic             out_free, out_load;

  mac_req_t         mreq;
  mac_rsp_t         mrsp;

  logic             row_we, pow_we;
  logic [IW-1:0]    row_waddr, pow_waddr, row_ra, row_rb;
  logic [WordW-1:0] row_wdata, pow_wdata, row_da, row_db, pow_da;

  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = (state == S_FIN) && last && out_free;
  assign inext         = {1'b0, i} + {{NW{1'b0}}, 1'b1};

  // reduced k = min(k, n - k)
  assign k64 = ((nn64 - kk64) < kk64) ? (nn64 - kk64) : kk64;

  // table ports
  assign row_ra = (state == S_FRD) ? k : j;
  assign row_rb = j - {{(IW-1){1'b0}}, 1'b1};

  always_comb begin
    row_we    = 1'b0;
    row_waddr = j;
    row_wdata = mrsp.res;
    pow_we    = 1'b0;
    pow_waddr = j;
    pow_wdata = mrsp.res;
    mreq.start = 1'b0;
    mreq.a     = pw;
    mreq.b     = field_size;
    mreq.c     = '0;
    unique case (state)
      S_PREP2: begin
        if (k64 != '0 && nn64 <= WordW'(MAX_REDUCED_N) && k64 <= WordW'(MAX_REDUCED_K)) begin
          row_we    = 1'b1;
          row_waddr = '0;
          row_wdata = 64'd1;
          pow_we    = 1'b1;
          pow_waddr = '0;
          pow_wdata = 64'd1;
        end
      end
      S_ISTART: mreq.start = 1'b1;
      S_IWAIT: begin
        if (mrsp.done && !mrsp.ovf) begin
          row_we    = 1'b1;
          row_wdata = '0;
          pow_we    = 1'b1;
        end
      end
      S_RDAT: begin
        mreq.start = 1'b1;
        mreq.a     = pow_da;
        mreq.b     = row_da;
        mreq.c     = row_db;
      end
      S_RWAIT: row_we = mrsp.done && !mrsp.ovf;
      S_FDAT: begin
        mreq.start = 1'b1;
        mreq.a     = prod;
        mreq.b     = one_fac ? 64'd1 : row_da;
      end
      default: ;
    endcase
  end

  fcgb_ram #(.Width(WordW), .Depth(Depth)) u_row (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .raddr_a(row_ra), .raddr_b(row_rb), .rdata_a(row_da), .rdata_b(row_db)
  );

  fcgb_ram #(.Width(WordW), .Depth(Depth)) u_pow (
    .clk(clk), .we(pow_we), .waddr(pow_waddr), .wdata(pow_wdata),
    .raddr_a(j), .raddr_b(j), .rdata_a(pow_da), .rdata_b()
  );

  fcgb_mac u_mac (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      field_size    <= FieldSizeReset;
      space_dim     <= '0;
      prod          <= 64'd1;
      prev          <= '0;
      started       <= 1'b0;
      inv_seen      <= 1'b0;
      ovf_seen      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          RegFieldSize: field_size <= cfg_data;
          RegSpaceDim:  space_dim  <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            d    <= s_axis_tdata;
            last <= s_axis_tlast;
            if (inv_seen || ovf_seen || s_axis_tdata > space_dim ||
                (started && prev >= s_axis_tdata)) begin
              inv_seen <= inv_seen || s_axis_tdata > space_dim ||
                          (started && prev >= s_axis_tdata);
              state    <= S_FIN;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          nn64  <= space_dim - prev;
          kk64  <= d - prev;
          state <= S_PREP2;
        end
        S_PREP2: begin
          one_fac <= 1'b0;
          if (k64 == '0) begin
            one_fac <= 1'b1;
            state   <= S_FDAT;
          end else if (nn64 > WordW'(MAX_REDUCED_N) || k64 > WordW'(MAX_REDUCED_K)) begin
            ovf_seen <= 1'b1;
            state    <= S_FIN;
          end else begin
            nn    <= nn64[NW-1:0];
            k     <= k64[IW-1:0];
            pw    <= 64'd1;
            j     <= {{(IW-1){1'b0}}, 1'b1};
            state <= S_ISTART;
          end
        end
        S_ISTART: state <= S_IWAIT;
        S_IWAIT: begin
          if (mrsp.done) begin
            if (mrsp.ovf) begin
              ovf_seen <= 1'b1;
              state    <= S_FIN;
            end else if (j == k) begin
              pw    <= mrsp.res;
              i     <= {{(NW-1){1'b0}}, 1'b1};
              j     <= {{(IW-1){1'b0}}, 1'b1};
              state <= S_RRD;
            end else begin
              pw    <= mrsp.res;
              j     <= j + {{(IW-1){1'b0}}, 1'b1};
              state <= S_ISTART;
            end
          end
        end
        S_RRD:  state <= S_RDAT;
        S_RDAT: state <= S_RWAIT;
        S_RWAIT: begin
          if (mrsp.done) begin
            if (mrsp.ovf) begin
              ovf_seen <= 1'b1;
              state    <= S_FIN;
            end else if (j == {{(IW-1){1'b0}}, 1'b1}) begin
              if (i == nn) begin
                state <= S_FRD;
              end else begin
                i     <= inext[NW-1:0];
                j     <= (inext < (NW+1)'(k)) ? inext[IW-1:0] : k;
                state <= S_RRD;
              end
            end else begin
              j     <= j - {{(IW-1){1'b0}}, 1'b1};
              state <= S_RRD;
            end
          end
        end
        S_FRD:  state <= S_FDAT;
        S_FDAT: state <= S_PWAIT;
        S_PWAIT: begin
          if (mrsp.done) begin
            if (mrsp.ovf) begin
              ovf_seen <= 1'b1;
            end else begin
              prod <= mrsp.res;
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!last) begin
            prev    <= d;
            started <= 1'b1;
            state   <= S_IDLE;
          end else if (out_free) begin
            m_axis_tdata  <= {7'd0, (!inv_seen && ovf_seen),
                              (inv_seen || ovf_seen) ? 64'd0 : prod};
            prod     <= 64'd1;
            prev     <= '0;
            started  <= 1'b0;
            inv_seen <= 1'b0;
            ovf_seen <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/core/fcgb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcgb_checker
// Port-level checks for the flag count unit, bound to the top level.
// ----------------------------------------------------------------------------
module fcgb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);
  // overflow status always carries a zero count
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[64] |-> m_axis_tdata[63:0] == 64'd0)
    else $error("overflow word with nonzero count");

  a_reset_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // a new result needs a word with tlast taken earlier
  a_new_after_last: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> !$rose(m_axis_tvalid))
    else $error("result without end of flag");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output dropped while stalled");
endmodule

bind flag_count_gaussian_binomial_unit fcgb_checker u_fcgb_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .s_axis_tlast(s_axis_tlast), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
